/* sv/mmar_pkg.sv */
// mmar_pkg: shared widths, payload types and sequencer codes for the
// modular multiply-accumulate block; no dependencies, compiled first
package mmar_pkg;

   localparam int DATA_WIDTH = 63;
   localparam int SUM_WIDTH  = DATA_WIDTH + 1;
   localparam int CNT_WIDTH  = $clog2(DATA_WIDTH);
   localparam int COL_WIDTH  = 12;

   typedef struct packed {
      logic [DATA_WIDTH-1:0] lhs;
      logic [DATA_WIDTH-1:0] rhs;
      logic [DATA_WIDTH-1:0] modulus;
      logic [DATA_WIDTH-1:0] prior_value;
      logic [COL_WIDTH-1:0]  dest_column;
      logic                  last_term;
   } req_payload_type;

   typedef struct packed {
      logic [DATA_WIDTH-1:0] value_out;
      logic [COL_WIDTH-1:0]  out_column;
   } rsp_payload_type;

   // result of the shared modular adder
   typedef struct packed {
      logic                  ge;
      logic [DATA_WIDTH-1:0] value;
   } modadd_res_type;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_CHECK,
      ST_REDUCE,
      ST_DOUBLE,
      ST_ADDX,
      ST_COMBINE
   } state_type;

   // which operand a reduction pass works on
   typedef enum logic [1:0] {
      PH_LHS,
      PH_SUM,
      PH_PRIOR
   } phase_type;

endpackage

/* sv/mmar_req_if.sv */
// mmar_req_if: valid/ready channel carrying one term of a run
// depends on mmar_pkg
interface mmar_req_if;
   import mmar_pkg::*;

   logic            valid;
   logic            ready;
   req_payload_type data;

   modport source (output valid, output data, input ready);
   modport sink   (input valid, input data, output ready);
endinterface

/* sv/mmar_rsp_if.sv */
// mmar_rsp_if: valid/ready channel carrying one finished element value
// depends on mmar_pkg
interface mmar_rsp_if;
   import mmar_pkg::*;

   logic            valid;
   logic            ready;
   rsp_payload_type data;

   modport source (output valid, output data, input ready);
   modport sink   (input valid, input data, output ready);
endinterface

/* sv/modular_mul_accumulate_reduce_top.sv */
// modular_mul_accumulate_reduce_top: sequencer, operand registers and the
// running sum around one shared modular adder
// depends on mmar_pkg, mmar_req_if, mmar_rsp_if and mmar_modadd
//
// usage
//  - req_chan carries one term per transfer: lhs, rhs, modulus, prior_value,
//    dest_column and last_term; a run of terms ends with last_term set
//  - rsp_chan carries one transfer per run: value_out is
//    (prior_value + sum of lhs*rhs) mod modulus, out_column the last tag
//  - req_chan.ready is high only while the sequencer is idle; one term is
//    taken, then worked through bit by bit on the single modular adder
//  - steps after the transfer: a range check per operand, 63 restoring
//    steps for each of lhs, running sum and (last term) prior value not
//    already below the modulus, 63 doubling steps, an add per set bit of rhs
//    and a combine (two on a last term); then back to idle
//  - zero modulus: the term ends at the range check, with a combine after it on a last term, which gives value 0
//  - the result sits in an output register; the next term is taken while it
//    waits, and only the final combine of the next run stalls on it
//  - synchronous reset clears the running sum, the sequencer and rsp valid
module modular_mul_accumulate_reduce_top (
   input  logic         clock,
   input  logic         reset,
   mmar_req_if.sink     req_chan,
   mmar_rsp_if.source   rsp_chan
);
   import mmar_pkg::*;

   state_type state_ff, state_in;
   phase_type phase_ff, phase_in;

   // latched term
   logic [DATA_WIDTH-1:0] lhs_ff, rhs_ff, mod_ff, prior_ff;
   logic [DATA_WIDTH-1:0] lhs_in, rhs_in, mod_in, prior_in;
   logic [COL_WIDTH-1:0]  col_ff, col_in;
   logic                  last_ff, last_in;

   // working registers
   logic [DATA_WIDTH-1:0] acc_ff, acc_in;
   logic [DATA_WIDTH-1:0] rem_ff, rem_in;
   logic [DATA_WIDTH-1:0] sum_ff, sum_in;
   logic [CNT_WIDTH-1:0]  cnt_ff, cnt_in;

   // output register
   logic                  rsp_valid_ff, rsp_valid_in;
   rsp_payload_type       rsp_data_ff, rsp_data_in;

   // shared unit
   logic [DATA_WIDTH-1:0] unit_a, unit_b;
   logic                  unit_cin;
   modadd_res_type        unit_res;

   logic [DATA_WIDTH-1:0] src;
   logic                  mod_zero;
   logic                  cnt_zero;
   logic                  rsp_blocked;
   logic                  red_done;

   mmar_modadd u_modadd (
      .a   (unit_a),
      .b   (unit_b),
      .cin (unit_cin),
      .m   (mod_ff),
      .res (unit_res)
   );

   // operand under reduction
   always_comb begin
      unique case (phase_ff)
         PH_LHS:   src = lhs_ff;
         PH_SUM:   src = sum_ff;
         PH_PRIOR: src = prior_ff;
         default:  src = lhs_ff;
      endcase
   end

   assign mod_zero    = (mod_ff == '0);
   assign cnt_zero    = (cnt_ff == '0);
   assign rsp_blocked = rsp_valid_ff && !rsp_chan.ready;
   // reduction pass finished this cycle (operand already in range or last step)
   assign red_done    = ((state_ff == ST_CHECK) && !mod_zero && !unit_res.ge) ||
                        ((state_ff == ST_REDUCE) && cnt_zero);

   assign req_chan.ready = (state_ff == ST_IDLE);
   assign rsp_chan.valid = rsp_valid_ff;
   assign rsp_chan.data  = rsp_data_ff;

   // shared adder operand selection
   always_comb begin
      unit_a   = '0;
      unit_b   = '0;
      unit_cin = 1'b0;
      unique case (state_ff)
         ST_CHECK: begin
            unit_a = src;
         end
         ST_REDUCE: begin
            unit_a   = rem_ff;
            unit_b   = rem_ff;
            unit_cin = src[cnt_ff];
         end
         ST_DOUBLE: begin
            unit_a = acc_ff;
            unit_b = acc_ff;
         end
         ST_ADDX, ST_COMBINE: begin
            unit_a = acc_ff;
            unit_b = rem_ff;
         end
         default: begin
            unit_a = '0;
         end
      endcase
   end

   // next state
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         ST_IDLE: begin
            if (req_chan.valid) state_in = ST_CHECK;
         end
         ST_CHECK: begin
            if (mod_zero) state_in = last_ff ? ST_COMBINE : ST_IDLE;
            else if (unit_res.ge) state_in = ST_REDUCE;
            else state_in = (phase_ff == PH_LHS) ? ST_DOUBLE : ST_COMBINE;
         end
         ST_REDUCE: begin
            if (cnt_zero) state_in = (phase_ff == PH_LHS) ? ST_DOUBLE : ST_COMBINE;
         end
         ST_DOUBLE: begin
            if (rhs_ff[cnt_ff]) state_in = ST_ADDX;
            else if (cnt_zero) state_in = ST_CHECK;
         end
         ST_ADDX: begin
            state_in = cnt_zero ? ST_CHECK : ST_DOUBLE;
         end
         ST_COMBINE: begin
            if (phase_ff == PH_SUM) state_in = last_ff ? ST_CHECK : ST_IDLE;
            else if (!rsp_blocked) state_in = ST_IDLE;
         end
         default: state_in = ST_IDLE;
      endcase
   end

   // datapath and output register updates
   always_comb begin
      phase_in     = phase_ff;
      lhs_in       = lhs_ff;
      rhs_in       = rhs_ff;
      mod_in       = mod_ff;
      prior_in     = prior_ff;
      col_in       = col_ff;
      last_in      = last_ff;
      acc_in       = acc_ff;
      rem_in       = rem_ff;
      sum_in       = sum_ff;
      cnt_in       = cnt_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_chan.ready;
      rsp_data_in  = rsp_data_ff;

      unique case (state_ff)
         ST_IDLE: begin
            if (req_chan.valid) begin
               lhs_in   = req_chan.data.lhs;
               rhs_in   = req_chan.data.rhs;
               mod_in   = req_chan.data.modulus;
               prior_in = req_chan.data.prior_value;
               // column tag space is the full 12-bit field
               col_in   = req_chan.data.dest_column;
               last_in  = req_chan.data.last_term;
               phase_in = PH_LHS;
            end
         end
         ST_CHECK: begin
            if (mod_zero) begin
               // zero modulus: everything collapses to zero
               acc_in   = '0;
               rem_in   = '0;
               sum_in   = '0;
               phase_in = PH_PRIOR;
            end else if (unit_res.ge) begin
               rem_in = '0;
               cnt_in = CNT_WIDTH'(DATA_WIDTH - 1);
            end else begin
               rem_in = src;
            end
         end
         ST_REDUCE: begin
            rem_in = unit_res.value;
            if (cnt_zero == 1'b0) cnt_in = cnt_ff - CNT_WIDTH'(1);
         end
         ST_DOUBLE: begin
            acc_in = unit_res.value;
         end
         ST_ADDX: begin
            acc_in = unit_res.value;
         end
         ST_COMBINE: begin
            if (phase_ff == PH_SUM) begin
               acc_in = unit_res.value;
               if (last_ff) phase_in = PH_PRIOR;
               else sum_in = unit_res.value;
            end else if (!rsp_blocked) begin
               sum_in                 = '0;
               rsp_valid_in           = 1'b1;
               rsp_data_in.value_out  = unit_res.value;
               rsp_data_in.out_column = col_ff;
            end
         end
         default: begin
            acc_in = acc_ff;
         end
      endcase

      // multiply loop setup after the lhs pass
      if (red_done && (phase_ff == PH_LHS)) begin
         acc_in = '0;
         cnt_in = CNT_WIDTH'(DATA_WIDTH - 1);
      end

      // multiply loop bit stepping
      if ((state_ff == ST_DOUBLE && !rhs_ff[cnt_ff]) || state_ff == ST_ADDX) begin
         if (cnt_zero) phase_in = PH_SUM;
         else cnt_in = cnt_ff - CNT_WIDTH'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         phase_ff     <= PH_LHS;
         sum_ff       <= '0;
         cnt_ff       <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         phase_ff     <= phase_in;
         sum_ff       <= sum_in;
         cnt_ff       <= cnt_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      lhs_ff      <= lhs_in;
      rhs_ff      <= rhs_in;
      mod_ff      <= mod_in;
      prior_ff    <= prior_in;
      col_ff      <= col_in;
      last_ff     <= last_in;
      acc_ff      <= acc_in;
      rem_ff      <= rem_in;
      rsp_data_ff <= rsp_data_in;
   end
endmodule

/* sv/mmar_modadd.sv */
// mmar_modadd: shared modular add step, (a + b + cin) with one conditional
// subtract of m; valid while a + b + cin < 2m. depends on mmar_pkg
module mmar_modadd (
   input  logic [mmar_pkg::DATA_WIDTH-1:0] a,
   input  logic [mmar_pkg::DATA_WIDTH-1:0] b,
   input  logic                            cin,
   input  logic [mmar_pkg::DATA_WIDTH-1:0] m,
   output mmar_pkg::modadd_res_type        res
);
   import mmar_pkg::*;

   logic [SUM_WIDTH-1:0] sum;
   logic [SUM_WIDTH-1:0] diff;

   assign sum  = {1'b0, a} + {1'b0, b} + {{(SUM_WIDTH-1){1'b0}}, cin};
   assign diff = sum - {1'b0, m};

   always_comb begin
      res.ge    = (sum >= {1'b0, m});
      res.value = res.ge ? diff[DATA_WIDTH-1:0] : sum[DATA_WIDTH-1:0];
   end
endmodule
